FILE: sv/iat_pkg.sv
// iat_pkg: token kinds, lexer phases, character classes and keyword table
// shared by the tokenizer step logic and the top level; no dependencies
`default_nettype none
package iat_pkg;

  localparam int KeywordCharsDef = 8;
  localparam int PositionBitsDef = 32;
  localparam int MaxTokens = 4;
  localparam int TokBits = 63; // kind 6 + indent 8 + start 32 + length 16 + last 1

  localparam logic [5:0] K_EOF     = 6'd0;
  localparam logic [5:0] K_EOL     = 6'd1;
  localparam logic [5:0] K_INDENT  = 6'd2;
  localparam logic [5:0] K_NUMBER  = 6'd3;
  localparam logic [5:0] K_STRING  = 6'd4;
  localparam logic [5:0] K_WORD    = 6'd5;
  localparam logic [5:0] K_KW0     = 6'd6;
  localparam logic [5:0] K_OP0     = 6'd16;
  localparam logic [5:0] K_OPEQ0   = 6'd24;
  localparam logic [5:0] K_PUNCT0  = 6'd32;
  localparam logic [5:0] K_UNKNOWN = 6'd40;

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_WORD  = 3'd1;
  localparam logic [2:0] PH_NUM   = 3'd2;
  localparam logic [2:0] PH_DOT   = 3'd3;
  localparam logic [2:0] PH_OPER  = 3'd4;
  localparam logic [2:0] PH_QUOTE = 3'd5;

  typedef struct packed {
    logic [5:0]  kind;
    logic [7:0]  indent_count;
    logic [31:0] start_offset;
    logic [15:0] token_length;
    logic        last_of_run;
  } tok_t;

  typedef struct packed {
    logic [2:0] phase;
    logic [2:0] held_op;
    logic       quote_dbl;
    logic       esc;
    logic       num_point;
    logic       in_comment;
    logic       line_start;
    logic       eol_pending;
    logic       any_sent;
    logic [7:0] indent;
    logic [15:0] lex_count;
  } lex_state_t;

  // lexer state after reset: idle at the start of a line
  localparam lex_state_t LexReset = '{
    phase: PH_IDLE, held_op: 3'd0, quote_dbl: 1'b0, esc: 1'b0, num_point: 1'b0,
    in_comment: 1'b0, line_start: 1'b1, eol_pending: 1'b0, any_sent: 1'b0,
    indent: 8'd0, lex_count: 16'd0
  };

  // keyword text, first character in the low byte, padded with zeros
  localparam logic [63:0] KW_TEXT [10] = '{
    64'h0000_6164_626d_616c, // lambda
    64'h0000_0000_0066_6564, // def
    64'h0000_6e72_7574_6572, // return
    64'h0000_0000_0000_6669, // if
    64'h0000_0000_6669_6c65, // elif
    64'h0000_0000_6573_6c65, // else
    64'h0000_0000_7373_6170, // pass
    64'h0000_0065_6c69_6877, // while
    64'h0000_006b_6165_7262, // break
    64'h6575_6e69_746e_6f63  // continue
  };
  localparam logic [3:0] KW_LEN [10] = '{4'd6, 4'd3, 4'd6, 4'd2, 4'd4,
                                         4'd4, 4'd4, 4'd5, 4'd5, 4'd8};

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic is_wordc(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == 8'h5f;
  endfunction

  function automatic logic is_break(input logic [7:0] c);
    return c == 8'h0d || c == 8'h0a;
  endfunction

  // operator index, bit 3 set when found
  function automatic logic [3:0] op_index(input logic [7:0] c);
    case (c)
      8'h3c:   return 4'h8;
      8'h3e:   return 4'h9;
      8'h21:   return 4'ha;
      8'h3d:   return 4'hb;
      8'h2b:   return 4'hc;
      8'h2d:   return 4'hd;
      8'h2a:   return 4'he;
      8'h2f:   return 4'hf;
      default: return 4'h0;
    endcase
  endfunction

  function automatic logic [3:0] punct_index(input logic [7:0] c);
    case (c)
      8'h2e:   return 4'h8;
      8'h2c:   return 4'h9;
      8'h3a:   return 4'ha;
      8'h3b:   return 4'hb;
      8'h28:   return 4'hc;
      8'h29:   return 4'hd;
      8'h5b:   return 4'he;
      8'h5d:   return 4'hf;
      default: return 4'h0;
    endcase
  endfunction

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == 16'hffff) ? v : v + 16'd1;
  endfunction

endpackage
`default_nettype wire

FILE: sv/iat_step.sv
// iat_step: combinational next state and up to four tokens for one input word
// depends on iat_pkg; keyword buffer supplied by the top level
`default_nettype none
module iat_step import iat_pkg::*; #(
  parameter int KEYWORD_CHARS = KeywordCharsDef,
  parameter int POSITION_BITS = PositionBitsDef
) (
  input  wire logic [7:0]                   c,
  input  wire logic                         eoi,
  input  wire lex_state_t                   st,
  input  wire logic [POSITION_BITS-1:0]     pos,
  input  wire logic [POSITION_BITS-1:0]     tstart,
  input  wire logic [KEYWORD_CHARS*8-1:0]   kwbuf,
  output lex_state_t                        st_nxt,
  output logic [POSITION_BITS-1:0]          tstart_nxt,
  output logic                              kw_we,
  output logic [2:0]                        tok_cnt,
  output tok_t                              toks [MaxTokens]
);

  function automatic logic [31:0] lo32(input logic [POSITION_BITS-1:0] v);
    logic [47:0] w;
    w = 48'(v);
    return w[31:0];
  endfunction

  // keyword lookup over the captured characters
  logic [5:0] word_kind;
  always_comb begin
    word_kind = K_WORD;
    for (int k = 0; k < 10; k++) begin
      logic hit;
      hit = (st.lex_count == 16'(KW_LEN[k]));
      for (int j = 0; j < 8; j++)
        if (j < int'(KW_LEN[k]) && kwbuf[j*8 +: 8] != KW_TEXT[k][j*8 +: 8]) hit = 1'b0;
      if (hit) word_kind = K_KW0 + 6'(k);
    end
  end

  // token of the phase being closed
  tok_t close_tok;
  logic close_v;
  always_comb begin
    close_tok = '0;
    close_tok.start_offset = lo32(tstart);
    close_v = 1'b1;
    case (st.phase)
      PH_WORD:  begin close_tok.kind = word_kind; close_tok.token_length = st.lex_count; end
      PH_NUM:   begin close_tok.kind = K_NUMBER; close_tok.token_length = st.lex_count; end
      PH_DOT:   begin close_tok.kind = K_PUNCT0; close_tok.token_length = 16'd1; end
      PH_OPER:  begin close_tok.kind = K_OP0 + 6'(st.held_op); close_tok.token_length = 16'd1; end
      PH_QUOTE: begin close_tok.kind = K_STRING; close_tok.token_length = st.lex_count; end
      default:  close_v = 1'b0;
    endcase
  end

  always_comb begin
    lex_state_t s;
    logic [POSITION_BITS-1:0] ts;
    logic taken;
    logic [2:0] n;
    tok_t t;
    logic [3:0] oi, pi;
    s = st;
    ts = tstart;
    taken = 1'b0;
    n = 3'd0;
    kw_we = 1'b0;
    oi = op_index(c);
    pi = punct_index(c);
    for (int i = 0; i < MaxTokens; i++) toks[i] = '0;
    t = '0;
    if (eoi) begin
      if (close_v) begin
        toks[0] = close_tok;
        n = 3'd1;
      end
      t.kind = K_EOF;
      t.start_offset = lo32(pos);
      toks[n[1:0]] = t;
      n = n + 3'd1;
      s = '0;
      s.line_start = 1'b1;
      ts = '0;
    end else begin
      // continue or close the open token
      case (st.phase)
        PH_WORD: begin
          if (is_wordc(c)) begin
            kw_we = 1'b1;
            s.lex_count = sat_inc(st.lex_count);
            taken = 1'b1;
          end else begin
            toks[0] = close_tok; n = 3'd1; s.phase = PH_IDLE;
          end
        end
        PH_NUM: begin
          if (is_digit(c)) begin
            s.lex_count = sat_inc(st.lex_count); taken = 1'b1;
          end else if (c == 8'h2e && !st.num_point) begin
            s.num_point = 1'b1; s.lex_count = sat_inc(st.lex_count); taken = 1'b1;
          end else begin
            toks[0] = close_tok; n = 3'd1; s.phase = PH_IDLE;
          end
        end
        PH_DOT: begin
          if (is_digit(c)) begin
            s.phase = PH_NUM; s.num_point = 1'b1; s.lex_count = 16'd2; taken = 1'b1;
          end else begin
            toks[0] = close_tok; n = 3'd1; s.phase = PH_IDLE;
          end
        end
        PH_OPER: begin
          s.phase = PH_IDLE;
          if (c == 8'h3d) begin
            t.kind = K_OPEQ0 + 6'(st.held_op);
            t.start_offset = lo32(tstart);
            t.token_length = 16'd2;
            toks[0] = t; n = 3'd1; taken = 1'b1;
          end else begin
            toks[0] = close_tok; n = 3'd1;
          end
        end
        PH_QUOTE: begin
          s.lex_count = sat_inc(st.lex_count);
          taken = 1'b1;
          if (st.esc) s.esc = 1'b0;
          else if (c == 8'h5c) s.esc = 1'b1;
          else if (c == (st.quote_dbl ? 8'h22 : 8'h27)) begin
            toks[0] = close_tok;
            toks[0].token_length = s.lex_count;
            n = 3'd1; s.phase = PH_IDLE;
          end
        end
        default: s.phase = PH_IDLE;
      endcase
      if (n != 3'd0) s.any_sent = 1'b1;
      // from an idle lexer: line breaks, indentation, comments, or start a new token
      if (!taken) begin
        if (s.in_comment || is_break(c)) begin
          if (is_break(c)) begin
            if (s.any_sent && !s.eol_pending) begin
              s.eol_pending = 1'b1;
              ts = pos;
            end
            s.in_comment = 1'b0;
            s.line_start = 1'b1;
            s.indent = 8'd0;
          end
        end else if (c == 8'h20 || c == 8'h09) begin
          if (s.line_start && s.indent != 8'hff) s.indent = s.indent + 8'd1;
        end else if (c == 8'h23) begin
          s.in_comment = 1'b1;
        end else begin
          if (s.line_start) begin
            if (s.eol_pending) begin
              t = '0;
              t.kind = K_EOL;
              t.start_offset = lo32(ts);
              t.token_length = 16'd1;
              toks[n[1:0]] = t;
              n = n + 3'd1;
            end
            s.eol_pending = 1'b0;
            t = '0;
            t.kind = K_INDENT;
            t.indent_count = s.indent;
            t.start_offset = lo32(pos);
            toks[n[1:0]] = t;
            n = n + 3'd1;
            s.line_start = 1'b0;
          end
          ts = pos;
          s.lex_count = 16'd1;
          t = '0;
          t.start_offset = lo32(pos);
          t.token_length = 16'd1;
          if (c == 8'h27 || c == 8'h22) begin
            s.phase = PH_QUOTE; s.quote_dbl = (c == 8'h22); s.esc = 1'b0;
          end else if (c == 8'h2e) begin
            s.phase = PH_DOT;
          end else if (is_digit(c)) begin
            s.phase = PH_NUM; s.num_point = 1'b0;
          end else if (oi[3]) begin
            s.phase = PH_OPER; s.held_op = oi[2:0];
          end else if (pi[3]) begin
            t.kind = K_PUNCT0 + 6'(pi[2:0]);
            toks[n[1:0]] = t; n = n + 3'd1;
          end else if (is_alpha(c) || c == 8'h5f) begin
            s.phase = PH_WORD;
            kw_we = 1'b1;
          end else begin
            t.kind = K_UNKNOWN;
            toks[n[1:0]] = t; n = n + 3'd1;
          end
          if (n != 3'd0) s.any_sent = 1'b1;
        end
      end
      if (n != 3'd0) toks[n[1:0] - 2'd1].last_of_run = 1'b1;
    end
    if (eoi) toks[n[1:0] - 2'd1].last_of_run = 1'b1;
    st_nxt = s;
    tstart_nxt = ts;
    tok_cnt = n;
  end

endmodule
`default_nettype wire

FILE: sv/indentation_aware_tokenizer_top.sv
// indentation_aware_tokenizer_top: one byte per cycle into the token stream
// latency: a word's first token shows on out_* the cycle after acceptance
// throughput: one input word per cycle while the queue keeps up; a word giving more than one token (up to four)
//   stalls the input while the token queue drains to its last entry, longer when out_tready is low
// reset: synchronous active-low rst_n clears lexer state and the token queue
// depends on iat_pkg and iat_step
`default_nettype none
module indentation_aware_tokenizer_top import iat_pkg::*; #(
  parameter int KEYWORD_CHARS = KeywordCharsDef,
  parameter int POSITION_BITS = PositionBitsDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,  // char_code
  input  wire logic        in_tlast,  // end_of_input
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata, // kind, indent_count, start_offset, token_length
  output logic             out_tlast  // last_of_run
);

  localparam int CW = $clog2(KEYWORD_CHARS);

  lex_state_t               st_r, st_nxt;
  logic [POSITION_BITS-1:0] pos_r, tstart_r, tstart_nxt;
  logic [7:0]               kw_r [KEYWORD_CHARS];
  logic [KEYWORD_CHARS*8-1:0] kwbuf;
  logic                     kw_we;
  logic [2:0]               tok_cnt;
  tok_t                     toks [MaxTokens];
  tok_t                     q_r [MaxTokens];
  logic [2:0]               qn_r;
  logic [1:0]               qh_r;
  logic                     acc, pop;

  always_comb
    for (int i = 0; i < KEYWORD_CHARS; i++) kwbuf[i*8 +: 8] = kw_r[i];

  iat_step #(.KEYWORD_CHARS(KEYWORD_CHARS), .POSITION_BITS(POSITION_BITS)) u_step (
    .c(in_tdata), .eoi(in_tlast), .st(st_r), .pos(pos_r), .tstart(tstart_r),
    .kwbuf(kwbuf), .st_nxt(st_nxt), .tstart_nxt(tstart_nxt), .kw_we(kw_we),
    .tok_cnt(tok_cnt), .toks(toks)
  );

  // accept when the token queue is empty or drains its last entry now
  assign pop = out_tvalid && out_tready;
  assign in_tready = (qn_r == 3'd0) || (qn_r == 3'd1 && pop);
  assign acc = in_tvalid && in_tready;

  // lexer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= LexReset;
      pos_r <= '0;
      tstart_r <= '0;
    end else if (acc) begin
      st_r <= st_nxt;
      tstart_r <= tstart_nxt;
      pos_r <= in_tlast ? '0 : pos_r + 1'b1;
    end
  end

  // keyword character capture, only the first KEYWORD_CHARS kept
  always_ff @(posedge clk) begin
    if (acc && kw_we) begin
      if (st_r.phase != PH_WORD || st_nxt.phase != PH_WORD || !acc)
        kw_r[0] <= in_tdata;
      else if (st_r.lex_count < 16'(KEYWORD_CHARS))
        kw_r[st_r.lex_count[CW-1:0]] <= in_tdata;
    end
  end

  // token queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qn_r <= '0;
      qh_r <= '0;
    end else if (acc) begin
      qn_r <= tok_cnt;
      qh_r <= '0;
    end else if (pop) begin
      qn_r <= qn_r - 3'd1;
      qh_r <= qh_r + 2'd1;
    end
  end

  always_ff @(posedge clk)
    if (acc) for (int i = 0; i < MaxTokens; i++) q_r[i] <= toks[i];

  assign out_tvalid = qn_r != 3'd0;
  assign out_tdata = {2'b00, q_r[qh_r].token_length, q_r[qh_r].start_offset,
                      q_r[qh_r].indent_count, q_r[qh_r].kind};
  assign out_tlast = q_r[qh_r].last_of_run;

`ifndef SYNTHESIS
  a_qn_max: assert property (@(posedge clk) disable iff (!rst_n) qn_r <= 3'd4)
    else $error("token queue overfull");
  a_eof_tok: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_tlast |=> out_tvalid)
    else $error("end mark gave no token");
  a_eof_reset: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_tlast |=> st_r.line_start && pos_r == '0)
    else $error("state not restarted after end mark");
  a_no_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    qn_r > 3'd1 |-> !in_tready)
    else $error("input taken while tokens wait");
`endif

endmodule
`default_nettype wire
